// ===== rtl/bwt_pkg.sv =====
package bwt_pkg;

  localparam int unsigned BLOCK_SIZE   = 4096;
  localparam int unsigned ALPHABET     = 256;
  localparam int unsigned BUCKET_DEPTH = BLOCK_SIZE + 1;
  localparam int unsigned AW           = 12;
  localparam int unsigned LW           = 13;

  typedef struct packed {
    logic          command;
    logic [7:0]    data_byte;
    logic          last;
    logic [AW-1:0] read_index;
  } bwt_item_t;

  typedef struct packed {
    logic [7:0]    bwt_byte;
    logic [AW-1:0] rot0_pos;
    logic [LW-1:0] block_length;
    logic          in_range;
  } bwt_result_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [5:0] {
    OP_IDLE,
    OP_NOP,
    OP_RD1,
    OP_RD2,
    OP_CLR,
    OP_BH1,
    OP_BH2,
    OP_BH3,
    OP_PFX_RD,
    OP_PFX_EX,
    OP_PFX_IN,
    OP_BD1,
    OP_BD2,
    OP_BD3,
    OP_ROT_RD,
    OP_K2,
    OP_K3,
    OP_E2,
    OP_CNT_KEY,
    OP_CNT_INC,
    OP_F2,
    OP_PLC_KEY,
    OP_PLC_SCR,
    OP_SCR_RD,
    OP_G2,
    OP_H2,
    OP_PLC_ROT,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_N1,
    OP_N2,
    OP_S2,
    OP_ROUND,
    OP_NEXT,
    OP_SEAL
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic read;
    logic i_inc;
    logic i_clr;
  } bwt_cmd_t;

  typedef struct packed {
    logic last_n;
    logic last_byte;
    logic last_size;
    logic top_full;
    logic gap_end;
  } bwt_sts_t;

endpackage

// ===== rtl/bwt_controller.sv =====
module bwt_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  bwt_pkg::bwt_item_t item_i,
  input  bwt_pkg::bwt_sts_t  sts_i,
  output bwt_pkg::bwt_cmd_t  cmd_o,
  output logic             busy,
  output logic             valid_o
);
  import bwt_pkg::*;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_RD1   = 6'd1;
  localparam logic [5:0] S_RD2   = 6'd2;
  localparam logic [5:0] S_CLR0  = 6'd3;
  localparam logic [5:0] S_BH1   = 6'd4;
  localparam logic [5:0] S_BH2   = 6'd5;
  localparam logic [5:0] S_BH3   = 6'd6;
  localparam logic [5:0] S_PX0A  = 6'd7;
  localparam logic [5:0] S_PX0B  = 6'd8;
  localparam logic [5:0] S_BD1   = 6'd9;
  localparam logic [5:0] S_BD2   = 6'd10;
  localparam logic [5:0] S_BD3   = 6'd11;
  localparam logic [5:0] S_K1    = 6'd12;
  localparam logic [5:0] S_K2    = 6'd13;
  localparam logic [5:0] S_K3    = 6'd14;
  localparam logic [5:0] S_CHK   = 6'd15;
  localparam logic [5:0] S_ROUND = 6'd16;
  localparam logic [5:0] S_CLRA  = 6'd17;
  localparam logic [5:0] S_E1    = 6'd18;
  localparam logic [5:0] S_E2    = 6'd19;
  localparam logic [5:0] S_E3    = 6'd20;
  localparam logic [5:0] S_E4    = 6'd21;
  localparam logic [5:0] S_PXAA  = 6'd22;
  localparam logic [5:0] S_PXAB  = 6'd23;
  localparam logic [5:0] S_F1    = 6'd24;
  localparam logic [5:0] S_F2    = 6'd25;
  localparam logic [5:0] S_F3    = 6'd26;
  localparam logic [5:0] S_F4    = 6'd27;
  localparam logic [5:0] S_CLRB  = 6'd28;
  localparam logic [5:0] S_G1    = 6'd29;
  localparam logic [5:0] S_G2    = 6'd30;
  localparam logic [5:0] S_G3    = 6'd31;
  localparam logic [5:0] S_G4    = 6'd32;
  localparam logic [5:0] S_PXBA  = 6'd33;
  localparam logic [5:0] S_PXBB  = 6'd34;
  localparam logic [5:0] S_H1    = 6'd35;
  localparam logic [5:0] S_H2    = 6'd36;
  localparam logic [5:0] S_H3    = 6'd37;
  localparam logic [5:0] S_H4    = 6'd38;
  localparam logic [5:0] S_M1    = 6'd39;
  localparam logic [5:0] S_M2    = 6'd40;
  localparam logic [5:0] S_M3    = 6'd41;
  localparam logic [5:0] S_M4    = 6'd42;
  localparam logic [5:0] S_N1    = 6'd43;
  localparam logic [5:0] S_N2    = 6'd44;
  localparam logic [5:0] S_NEXT  = 6'd45;
  localparam logic [5:0] S_S1    = 6'd46;
  localparam logic [5:0] S_S2    = 6'd47;
  localparam logic [5:0] S_SEAL  = 6'd48;

  logic [5:0] state_q, state_d;
  logic       fin, lst;
  logic [5:0] loop_to, exit_to;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.op  = OP_NOP;
    fin       = 1'b0;
    lst       = 1'b0;
    loop_to   = S_IDLE;
    exit_to   = S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op = OP_IDLE;
        if (start) begin
          if (item_i.command == CMD_READ) begin
            cmd_o.read = 1'b1;
            state_d    = S_RD1;
          end else begin
            cmd_o.load = 1'b1;
            if (item_i.last) state_d = S_CLR0;
          end
        end
      end
      S_RD1:   begin cmd_o.op = OP_RD1; state_d = S_RD2; end
      S_RD2:   begin cmd_o.op = OP_RD2; state_d = S_IDLE; end
      S_CLR0:  begin
        cmd_o.op = OP_CLR; fin = 1'b1; lst = sts_i.last_byte; loop_to = S_CLR0; exit_to = S_BH1;
      end
      S_BH1:   begin cmd_o.op = OP_BH1; state_d = S_BH2; end
      S_BH2:   begin cmd_o.op = OP_BH2; state_d = S_BH3; end
      S_BH3:   begin
        cmd_o.op = OP_BH3; fin = 1'b1; lst = sts_i.last_n; loop_to = S_BH1; exit_to = S_PX0A;
      end
      S_PX0A:  begin cmd_o.op = OP_PFX_RD; state_d = S_PX0B; end
      S_PX0B:  begin
        cmd_o.op = OP_PFX_EX; fin = 1'b1; lst = sts_i.last_byte; loop_to = S_PX0A;
        exit_to = S_BD1;
      end
      S_BD1:   begin cmd_o.op = OP_BD1; state_d = S_BD2; end
      S_BD2:   begin cmd_o.op = OP_BD2; state_d = S_BD3; end
      S_BD3:   begin
        cmd_o.op = OP_BD3; fin = 1'b1; lst = sts_i.last_n; loop_to = S_BD1; exit_to = S_K1;
      end
      S_K1:    begin cmd_o.op = OP_ROT_RD; state_d = S_K2; end
      S_K2:    begin cmd_o.op = OP_K2; state_d = S_K3; end
      S_K3:    begin
        cmd_o.op = OP_K3; fin = 1'b1; lst = sts_i.last_n; loop_to = S_K1; exit_to = S_CHK;
      end
      S_CHK:   begin
        cmd_o.op = OP_NOP;
        state_d  = (sts_i.gap_end || sts_i.top_full) ? S_S1 : S_ROUND;
      end
      S_ROUND: begin cmd_o.op = OP_ROUND; state_d = S_CLRA; end
      S_CLRA:  begin
        cmd_o.op = OP_CLR; fin = 1'b1; lst = sts_i.last_size; loop_to = S_CLRA; exit_to = S_E1;
      end
      S_E1:    begin cmd_o.op = OP_ROT_RD; state_d = S_E2; end
      S_E2:    begin cmd_o.op = OP_E2; state_d = S_E3; end
      S_E3:    begin cmd_o.op = OP_CNT_KEY; state_d = S_E4; end
      S_E4:    begin
        cmd_o.op = OP_CNT_INC; fin = 1'b1; lst = sts_i.last_n; loop_to = S_E1; exit_to = S_PXAA;
      end
      S_PXAA:  begin cmd_o.op = OP_PFX_RD; state_d = S_PXAB; end
      S_PXAB:  begin
        cmd_o.op = OP_PFX_IN; fin = 1'b1; lst = sts_i.last_size; loop_to = S_PXAA;
        exit_to = S_F1;
      end
      S_F1:    begin cmd_o.op = OP_ROT_RD; state_d = S_F2; end
      S_F2:    begin cmd_o.op = OP_F2; state_d = S_F3; end
      S_F3:    begin cmd_o.op = OP_PLC_KEY; state_d = S_F4; end
      S_F4:    begin
        cmd_o.op = OP_PLC_SCR; fin = 1'b1; lst = sts_i.last_n; loop_to = S_F1; exit_to = S_CLRB;
      end
      S_CLRB:  begin
        cmd_o.op = OP_CLR; fin = 1'b1; lst = sts_i.last_size; loop_to = S_CLRB; exit_to = S_G1;
      end
      S_G1:    begin cmd_o.op = OP_SCR_RD; state_d = S_G2; end
      S_G2:    begin cmd_o.op = OP_G2; state_d = S_G3; end
      S_G3:    begin cmd_o.op = OP_CNT_KEY; state_d = S_G4; end
      S_G4:    begin
        cmd_o.op = OP_CNT_INC; fin = 1'b1; lst = sts_i.last_n; loop_to = S_G1; exit_to = S_PXBA;
      end
      S_PXBA:  begin cmd_o.op = OP_PFX_RD; state_d = S_PXBB; end
      S_PXBB:  begin
        cmd_o.op = OP_PFX_IN; fin = 1'b1; lst = sts_i.last_size; loop_to = S_PXBA;
        exit_to = S_H1;
      end
      S_H1:    begin cmd_o.op = OP_SCR_RD; state_d = S_H2; end
      S_H2:    begin cmd_o.op = OP_H2; state_d = S_H3; end
      S_H3:    begin cmd_o.op = OP_PLC_KEY; state_d = S_H4; end
      S_H4:    begin
        cmd_o.op = OP_PLC_ROT; fin = 1'b1; lst = sts_i.last_n; loop_to = S_H1; exit_to = S_M1;
      end
      S_M1:    begin cmd_o.op = OP_ROT_RD; state_d = S_M2; end
      S_M2:    begin cmd_o.op = OP_M2; state_d = S_M3; end
      S_M3:    begin cmd_o.op = OP_M3; state_d = S_M4; end
      S_M4:    begin
        cmd_o.op = OP_M4; fin = 1'b1; lst = sts_i.last_n; loop_to = S_M1; exit_to = S_N1;
      end
      S_N1:    begin cmd_o.op = OP_N1; state_d = S_N2; end
      S_N2:    begin
        cmd_o.op = OP_N2; fin = 1'b1; lst = sts_i.last_n; loop_to = S_N1; exit_to = S_NEXT;
      end
      S_NEXT:  begin cmd_o.op = OP_NEXT; state_d = S_CHK; end
      S_S1:    begin cmd_o.op = OP_ROT_RD; state_d = S_S2; end
      S_S2:    begin
        cmd_o.op = OP_S2; fin = 1'b1; lst = sts_i.last_n; loop_to = S_S1; exit_to = S_SEAL;
      end
      S_SEAL:  begin cmd_o.op = OP_SEAL; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      if (lst) begin
        cmd_o.i_clr = 1'b1;
        state_d     = exit_to;
      end else begin
        cmd_o.i_inc = 1'b1;
        state_d     = loop_to;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_RD2);

endmodule

// ===== rtl/bwt_datapath.sv =====
module bwt_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bwt_pkg::bwt_item_t   item_i,
  input  bwt_pkg::bwt_cmd_t    cmd_i,
  output bwt_pkg::bwt_sts_t    sts_o,
  output bwt_pkg::bwt_result_t result_o
);
  import bwt_pkg::*;

  logic [7:0]    blk_mem [0:BLOCK_SIZE-1];
  logic [AW-1:0] rot_mem [0:BLOCK_SIZE-1];
  logic [AW-1:0] scr_mem [0:BLOCK_SIZE-1];
  logic [AW-1:0] rnk_mem [0:BLOCK_SIZE-1];
  logic [AW-1:0] nrk_mem [0:BLOCK_SIZE-1];
  logic [LW-1:0] bkt_mem [0:BUCKET_DEPTH-1];

  logic [7:0]    blk_rd, blk_wd;
  logic [AW-1:0] blk_ra, blk_wa;
  logic          blk_we;
  logic [AW-1:0] rot_rd, rot_ra, rot_wa, rot_wd;
  logic          rot_we;
  logic [AW-1:0] scr_rd, scr_ra, scr_wa, scr_wd;
  logic          scr_we;
  logic [AW-1:0] rnk_rd, rnk_ra, rnk_wa, rnk_wd;
  logic          rnk_we;
  logic [AW-1:0] nrk_rd, nrk_ra, nrk_wa, nrk_wd;
  logic          nrk_we;
  logic [LW-1:0] bkt_rd, bkt_ra, bkt_wa, bkt_wd;
  logic          bkt_we;

  logic [LW-1:0] fill_q, fill_d;
  logic          sealed_q, sealed_d;
  logic [AW-1:0] prim_q, prim_d;
  logic [LW-1:0] gap_q, gap_d;
  logic [LW-1:0] size_q, size_d;
  logic [LW-1:0] i_q, i_d;
  logic [LW-1:0] acc_q, acc_d;
  logic [LW-1:0] key_q, key_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] r1_q, r1_d;
  logic [AW-1:0] pr1_q, pr1_d;
  logic [AW-1:0] pr2_q, pr2_d;
  logic [AW-1:0] prev_r_q, prev_r_d;
  logic [7:0]    prev_byte_q, prev_byte_d;
  logic [AW-1:0] top_q, top_d;
  logic          inr_q, inr_d;

  logic [LW-1:0] load_base;
  logic [LW-1:0] n_m1;
  logic [AW-1:0] pred_pos;
  logic [AW-1:0] wrap_rot, wrap_a;
  logic [AW-1:0] new_rank;
  logic          same_pair;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] x,
                                              input logic [LW-1:0] g,
                                              input logic [LW-1:0] n);
    logic [LW-1:0] s;
    s = {1'b0, x} + g;
    if (s >= n) s = s - n;
    return s[AW-1:0];
  endfunction

  assign n_m1      = fill_q - LW'(1);
  assign load_base = sealed_q ? '0 : fill_q;
  assign pred_pos  = (rot_rd == '0) ? n_m1[AW-1:0] : rot_rd - AW'(1);
  assign wrap_rot  = wrap_add(rot_rd, gap_q, fill_q);
  assign wrap_a    = wrap_add(a_q, gap_q, fill_q);
  assign same_pair = (r1_q == pr1_q) && (rnk_rd == pr2_q);

  always_comb begin
    blk_ra = i_q[AW-1:0]; blk_we = 1'b0; blk_wa = '0; blk_wd = item_i.data_byte;
    rot_ra = i_q[AW-1:0]; rot_we = 1'b0; rot_wa = bkt_rd[AW-1:0]; rot_wd = a_q;
    scr_ra = i_q[AW-1:0]; scr_we = 1'b0; scr_wa = bkt_rd[AW-1:0]; scr_wd = a_q;
    rnk_ra = '0;          rnk_we = 1'b0; rnk_wa = a_q;            rnk_wd = '0;
    nrk_ra = i_q[AW-1:0]; nrk_we = 1'b0; nrk_wa = a_q;            nrk_wd = '0;
    bkt_ra = i_q;         bkt_we = 1'b0; bkt_wa = key_q;          bkt_wd = bkt_rd + LW'(1);

    fill_d = fill_q; sealed_d = sealed_q; prim_d = prim_q; gap_d = gap_q; size_d = size_q;
    acc_d = acc_q; key_d = key_q; a_d = a_q; r1_d = r1_q; pr1_d = pr1_q; pr2_d = pr2_q;
    prev_r_d = prev_r_q; prev_byte_d = prev_byte_q; top_d = top_q; inr_d = inr_q;
    new_rank = '0;

    i_d = i_q;
    if (cmd_i.i_clr) i_d = '0;
    else if (cmd_i.i_inc) i_d = i_q + LW'(1);

    case (cmd_i.op)
      OP_IDLE: begin
        if (cmd_i.load) begin
          sealed_d = 1'b0;
          gap_d    = LW'(1);
          if (sealed_q) prim_d = '0;
          if (load_base < LW'(BLOCK_SIZE)) begin
            blk_we = 1'b1;
            blk_wa = load_base[AW-1:0];
            fill_d = load_base + LW'(1);
          end else begin
            fill_d = load_base;
          end
        end
        if (cmd_i.read) begin
          rot_ra = item_i.read_index;
          inr_d  = sealed_q && ({1'b0, item_i.read_index} < fill_q);
        end
      end
      OP_RD1:    blk_ra = pred_pos;
      OP_CLR: begin
        bkt_we = 1'b1; bkt_wa = i_q; bkt_wd = '0; acc_d = '0;
      end
      OP_BH1:    blk_ra = i_q[AW-1:0];
      OP_BH2: begin
        bkt_ra = {{(LW-8){1'b0}}, blk_rd};
        key_d  = {{(LW-8){1'b0}}, blk_rd};
      end
      OP_BH3:    bkt_we = 1'b1;
      OP_PFX_RD: bkt_ra = i_q;
      OP_PFX_EX: begin
        bkt_we = 1'b1; bkt_wa = i_q; bkt_wd = acc_q; acc_d = acc_q + bkt_rd;
      end
      OP_PFX_IN: begin
        bkt_we = 1'b1; bkt_wa = i_q; bkt_wd = acc_q + bkt_rd; acc_d = acc_q + bkt_rd;
      end
      OP_BD1:    blk_ra = i_q[AW-1:0];
      OP_BD2: begin
        bkt_ra = {{(LW-8){1'b0}}, blk_rd};
        key_d  = {{(LW-8){1'b0}}, blk_rd};
      end
      OP_BD3: begin
        rot_we = 1'b1; rot_wd = i_q[AW-1:0]; bkt_we = 1'b1;
      end
      OP_ROT_RD: rot_ra = i_q[AW-1:0];
      OP_K2: begin
        a_d = rot_rd; blk_ra = rot_rd;
      end
      OP_K3: begin
        new_rank = (i_q == '0) ? '0 : prev_r_q + AW'(blk_rd != prev_byte_q);
        rnk_we = 1'b1; rnk_wd = new_rank;
        nrk_we = 1'b1; nrk_wd = new_rank;
        prev_byte_d = blk_rd; prev_r_d = new_rank; top_d = new_rank;
      end
      OP_E2:     rnk_ra = wrap_rot;
      OP_CNT_KEY: begin
        key_d  = {1'b0, rnk_rd} + LW'(1);
        bkt_ra = {1'b0, rnk_rd} + LW'(1);
      end
      OP_CNT_INC: bkt_we = 1'b1;
      OP_F2: begin
        a_d = rot_rd; rnk_ra = wrap_rot;
      end
      OP_PLC_KEY: begin
        key_d = {1'b0, rnk_rd}; bkt_ra = {1'b0, rnk_rd};
      end
      OP_PLC_SCR: begin
        scr_we = 1'b1; bkt_we = 1'b1;
      end
      OP_SCR_RD: scr_ra = i_q[AW-1:0];
      OP_G2:     rnk_ra = scr_rd;
      OP_H2: begin
        a_d = scr_rd; rnk_ra = scr_rd;
      end
      OP_PLC_ROT: begin
        rot_we = 1'b1; bkt_we = 1'b1;
      end
      OP_M2: begin
        a_d = rot_rd; rnk_ra = rot_rd;
      end
      OP_M3: begin
        r1_d = rnk_rd; rnk_ra = wrap_a;
      end
      OP_M4: begin
        new_rank = (i_q == '0) ? '0 : prev_r_q + AW'(!same_pair);
        nrk_we = 1'b1; nrk_wd = new_rank;
        pr1_d = r1_q; pr2_d = rnk_rd; prev_r_d = new_rank; top_d = new_rank;
      end
      OP_N1:     nrk_ra = i_q[AW-1:0];
      OP_N2: begin
        rnk_we = 1'b1; rnk_wa = i_q[AW-1:0]; rnk_wd = nrk_rd;
      end
      OP_S2: begin
        if (rot_rd == '0) prim_d = i_q[AW-1:0];
      end
      OP_ROUND:  size_d = {1'b0, top_q} + LW'(2);
      OP_NEXT:   gap_d = {gap_q[LW-2:0], 1'b0};
      OP_SEAL:   sealed_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    blk_rd <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rot_we) rot_mem[rot_wa] <= rot_wd;
    rot_rd <= rot_mem[rot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    scr_rd <= scr_mem[scr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rnk_we) rnk_mem[rnk_wa] <= rnk_wd;
    rnk_rd <= rnk_mem[rnk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nrk_we) nrk_mem[nrk_wa] <= nrk_wd;
    nrk_rd <= nrk_mem[nrk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_rd <= bkt_mem[bkt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sealed_q <= 1'b0;
      prim_q   <= '0;
      gap_q    <= LW'(1);
      i_q      <= '0;
    end else begin
      fill_q   <= fill_d;
      sealed_q <= sealed_d;
      prim_q   <= prim_d;
      gap_q    <= gap_d;
      i_q      <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q      <= size_d;
    acc_q       <= acc_d;
    key_q       <= key_d;
    a_q         <= a_d;
    r1_q        <= r1_d;
    pr1_q       <= pr1_d;
    pr2_q       <= pr2_d;
    prev_r_q    <= prev_r_d;
    prev_byte_q <= prev_byte_d;
    top_q       <= top_d;
    inr_q       <= inr_d;
  end

  assign sts_o.last_n    = (i_q == n_m1);
  assign sts_o.last_byte = (i_q == LW'(ALPHABET - 1));
  assign sts_o.last_size = (i_q == size_q - LW'(1));
  assign sts_o.top_full  = ({1'b0, top_q} == n_m1);
  assign sts_o.gap_end   = (gap_q >= fill_q);

  assign result_o.bwt_byte     = inr_q ? blk_rd : 8'd0;
  assign result_o.rot0_pos     = prim_q;
  assign result_o.block_length = fill_q;
  assign result_o.in_range     = inr_q;

endmodule

// ===== rtl/bwt_forward_transform.sv =====
// load word: no result; a plain load leaves busy low, a load marked last holds busy high
// for the sort: a first bucket round, doubling rounds until all ranks differ or the gap
// reaches the block length, then a scan of the sorted rotations to find the primary index
// read word: result strobed in state RD2, after RD1; a new word is taken once busy is low
// reset clears control state only; the block and sort memories are not initialized
module bwt_forward_transform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bwt_pkg::bwt_item_t   item_i,
  output logic                 result_valid_o,
  output bwt_pkg::bwt_result_t result_o
);
  import bwt_pkg::*;

  bwt_cmd_t cmd;
  bwt_sts_t sts;

  bwt_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy),
    .valid_o (result_valid_o)
  );

  bwt_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_read_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CMD_READ) |-> ##2 result_valid_o)
    else $error("read word not answered");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result repeated");

  a_plain_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CMD_LOAD && !item_i.last) |=> !busy)
    else $error("plain load stalled");
`endif

endmodule
